@@ rtl/bsrf_pkg.sv @@
// Package for the bind state redundancy filter.
// Holds the command and result types, action codes and fixed constants.
// No dependencies.
`default_nettype none

package bsrf_pkg;

  localparam int NAME_W  = 32;
  localparam int UNIT_W  = 8;
  localparam int ACT_W   = 3;
  localparam int SKIP_W  = 6;
  localparam int COUNT_W = 64;

  localparam logic [NAME_W-1:0] UNKNOWN_NAME = 32'hffff_ffff;

  localparam logic [ACT_W-1:0] ACT_VAO_BIND    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TEX_BIND    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_VAO_DELETE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TEX_DELETE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BOUND_QUERY = 3'd4;
  localparam logic [ACT_W-1:0] ACT_INVALIDATE  = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [UNIT_W-1:0] unit;
    logic [NAME_W-1:0] object_name;
  } cmd_t;

  typedef struct packed {
    logic               emit_vao_bind;
    logic               emit_unit_select;
    logic               emit_tex_bind;
    logic [UNIT_W-1:0]  fwd_unit;
    logic [NAME_W-1:0]  fwd_name;
    logic               verify_sample;
    logic               bound_hit;
    logic [COUNT_W-1:0] vao_request_count;
    logic [COUNT_W-1:0] vao_bind_count;
    logic [COUNT_W-1:0] tex_request_count;
    logic [COUNT_W-1:0] tex_bind_count;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/bind_state_redundancy_filter.sv @@
// Bind state redundancy filter, top level; uses bsrf_pkg and the three stages.
// Path: the input register captures a command, then the combinational state compare
// and update feed the result register.
// Throughput: one command per cycle unless out_stall holds the result register.
// Reset (rst_n low, synchronous): both stages empty, all cached names unknown,
// active unit unknown, skip, request and bind counters zero.
`default_nettype none

module bind_state_redundancy_filter
  import bsrf_pkg::*;
#(
  parameter int CACHED_UNITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [UNIT_W-1:0]  in_unit,
  input  wire logic [NAME_W-1:0]  in_object_name,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_emit_vao_bind,
  output logic                    out_emit_unit_select,
  output logic                    out_emit_tex_bind,
  output logic [UNIT_W-1:0]       out_fwd_unit,
  output logic [NAME_W-1:0]       out_fwd_name,
  output logic                    out_verify_sample,
  output logic                    out_bound_hit,
  output logic [COUNT_W-1:0]      out_vao_request_count,
  output logic [COUNT_W-1:0]      out_vao_bind_count,
  output logic [COUNT_W-1:0]      out_tex_request_count,
  output logic [COUNT_W-1:0]      out_tex_bind_count
);

  cmd_t    cmd_in, cmd;
  logic    cmd_vld, advance;
  result_t res, res_q;

  assign cmd_in.action      = in_action;
  assign cmd_in.unit        = in_unit;
  assign cmd_in.object_name = in_object_name;

  bsrf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd_in   (cmd_in),
    .advance  (advance),
    .cmd_vld  (cmd_vld),
    .cmd_out  (cmd)
  );

  bsrf_state #(
    .CACHED_UNITS (CACHED_UNITS)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cmd     (cmd),
    .res     (res)
  );

  bsrf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (cmd_vld),
    .res_in    (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_emit_vao_bind     = res_q.emit_vao_bind;
  assign out_emit_unit_select  = res_q.emit_unit_select;
  assign out_emit_tex_bind     = res_q.emit_tex_bind;
  assign out_fwd_unit          = res_q.fwd_unit;
  assign out_fwd_name          = res_q.fwd_name;
  assign out_verify_sample     = res_q.verify_sample;
  assign out_bound_hit         = res_q.bound_hit;
  assign out_vao_request_count = res_q.vao_request_count;
  assign out_vao_bind_count    = res_q.vao_bind_count;
  assign out_tex_request_count = res_q.tex_request_count;
  assign out_tex_bind_count    = res_q.tex_bind_count;

endmodule

`default_nettype wire

@@ rtl/bsrf_in_stage.sv @@
// Input register of the bind state redundancy filter.
// Captures one command per transfer; depends on bsrf_pkg.
`default_nettype none

module bsrf_in_stage
  import bsrf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire cmd_t cmd_in,
  input  wire logic advance,
  output logic      cmd_vld,
  output cmd_t      cmd_out
);

  logic vld_r;
  cmd_t cmd_r;

  // The register is held only while it is full and cannot move on.
  assign in_stall = vld_r & ~advance;
  assign cmd_vld  = vld_r;
  assign cmd_out  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsrf_state.sv @@
// Binding state cache, skip counters and request counters.
// Decides what each command forwards and updates state; depends on bsrf_pkg.
`default_nettype none

module bsrf_state
  import bsrf_pkg::*;
#(
  parameter int CACHED_UNITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  input  wire cmd_t cmd,
  output result_t   res
);

  localparam logic [UNIT_W:0] NUM_UNITS = (UNIT_W+1)'(CACHED_UNITS);

  logic [NAME_W-1:0]  cached_vao_r, cached_vao_nxt;
  logic [NAME_W-1:0]  cached_tex_r [CACHED_UNITS];
  logic [NAME_W-1:0]  cached_tex_nxt [CACHED_UNITS];
  logic [SKIP_W-1:0]  skip_r [CACHED_UNITS];
  logic [SKIP_W-1:0]  skip_nxt [CACHED_UNITS];
  logic [UNIT_W-1:0]  cur_unit_r, cur_unit_nxt;
  logic               unit_known_r, unit_known_nxt;
  logic [COUNT_W-1:0] vao_req_r, vao_req_nxt;
  logic [COUNT_W-1:0] vao_bind_r, vao_bind_nxt;
  logic [COUNT_W-1:0] tex_req_r, tex_req_nxt;
  logic [COUNT_W-1:0] tex_bind_r, tex_bind_nxt;

  logic [CACHED_UNITS-1:0] unit_sel, name_eq, skip_zero;
  logic act_vao, act_tex, act_vao_del, act_tex_del, act_query, act_inval;
  logic cached, tex_hit, sample, unit_diff, e_vao, e_sel, e_tex;

  always_comb begin
    act_vao     = cmd.action == ACT_VAO_BIND;
    act_tex     = cmd.action == ACT_TEX_BIND;
    act_vao_del = cmd.action == ACT_VAO_DELETE;
    act_tex_del = cmd.action == ACT_TEX_DELETE;
    act_query   = cmd.action == ACT_BOUND_QUERY;
    act_inval   = cmd.action == ACT_INVALIDATE;

    cached = {1'b0, cmd.unit} < NUM_UNITS;
    for (int i = 0; i < CACHED_UNITS; i++) begin
      unit_sel[i]  = cmd.unit == UNIT_W'(i);
      name_eq[i]   = cached_tex_r[i] == cmd.object_name;
      skip_zero[i] = skip_r[i] == '0;
    end
    // Only cached units can have a select bit, so a hit implies a cached unit.
    tex_hit   = |(unit_sel & name_eq);
    sample    = |(unit_sel & skip_zero);
    unit_diff = ~unit_known_r | (cur_unit_r != cmd.unit);

    e_vao = act_vao & (cmd.object_name != cached_vao_r);
    e_sel = act_tex & unit_diff;
    e_tex = act_tex & ~tex_hit;

    cached_vao_nxt = cached_vao_r;
    if (act_inval || (act_vao_del && cached_vao_r == cmd.object_name)) begin
      cached_vao_nxt = UNKNOWN_NAME;
    end else if (e_vao) begin
      cached_vao_nxt = cmd.object_name;
    end

    for (int i = 0; i < CACHED_UNITS; i++) begin
      cached_tex_nxt[i] = cached_tex_r[i];
      skip_nxt[i]       = skip_r[i];
      if (act_inval || (act_tex_del && name_eq[i])) begin
        cached_tex_nxt[i] = UNKNOWN_NAME;
      end else if (act_tex && unit_sel[i] && cached && !name_eq[i]) begin
        cached_tex_nxt[i] = cmd.object_name;
      end
      if (act_tex && unit_sel[i] && name_eq[i]) begin
        skip_nxt[i] = skip_r[i] + SKIP_W'(1);
      end
    end

    cur_unit_nxt   = e_sel ? cmd.unit : cur_unit_r;
    unit_known_nxt = act_inval ? 1'b0 : (unit_known_r | e_sel);

    vao_req_nxt  = vao_req_r + COUNT_W'(act_vao);
    vao_bind_nxt = vao_bind_r + COUNT_W'(e_vao);
    tex_req_nxt  = tex_req_r + COUNT_W'(act_tex);
    tex_bind_nxt = tex_bind_r + COUNT_W'(e_tex);

    res.emit_vao_bind     = e_vao;
    res.emit_unit_select  = e_sel;
    res.emit_tex_bind     = e_tex;
    res.fwd_unit          = (e_sel | e_tex) ? cmd.unit : '0;
    res.fwd_name          = (e_vao | e_tex) ? cmd.object_name : '0;
    res.verify_sample     = act_tex & tex_hit & sample;
    res.bound_hit         = act_query & tex_hit;
    res.vao_request_count = vao_req_nxt;
    res.vao_bind_count    = vao_bind_nxt;
    res.tex_request_count = tex_req_nxt;
    res.tex_bind_count    = tex_bind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_vao_r <= UNKNOWN_NAME;
      for (int i = 0; i < CACHED_UNITS; i++) begin
        cached_tex_r[i] <= UNKNOWN_NAME;
        skip_r[i]       <= '0;
      end
      cur_unit_r   <= '0;
      unit_known_r <= 1'b0;
      vao_req_r    <= '0;
      vao_bind_r   <= '0;
      tex_req_r    <= '0;
      tex_bind_r   <= '0;
    end else if (advance) begin
      cached_vao_r <= cached_vao_nxt;
      for (int i = 0; i < CACHED_UNITS; i++) begin
        cached_tex_r[i] <= cached_tex_nxt[i];
        skip_r[i]       <= skip_nxt[i];
      end
      cur_unit_r   <= cur_unit_nxt;
      unit_known_r <= unit_known_nxt;
      vao_req_r    <= vao_req_nxt;
      vao_bind_r   <= vao_bind_nxt;
      tex_req_r    <= tex_req_nxt;
      tex_bind_r   <= tex_bind_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsrf_out_stage.sv @@
// Result register of the bind state redundancy filter.
// Holds one result until its transfer completes; depends on bsrf_pkg.
`default_nettype none

module bsrf_out_stage
  import bsrf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_vld,
  input  wire result_t res_in,
  output logic         advance,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res_out
);

  logic    vld_r;
  result_t res_r;

  assign advance   = res_vld & (~vld_r | ~out_stall);
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || !out_stall) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsrf_checker.sv @@
// Port-level assertions for the bind state redundancy filter.
// Bound to bind_state_redundancy_filter below; depends on bsrf_pkg.
`default_nettype none

module bsrf_checker
  import bsrf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [ACT_W-1:0]   in_action,
  input wire logic [UNIT_W-1:0]  in_unit,
  input wire logic [NAME_W-1:0]  in_object_name,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_emit_vao_bind,
  input wire logic               out_emit_unit_select,
  input wire logic               out_emit_tex_bind,
  input wire logic [UNIT_W-1:0]  out_fwd_unit,
  input wire logic [NAME_W-1:0]  out_fwd_name,
  input wire logic               out_verify_sample,
  input wire logic               out_bound_hit,
  input wire logic [COUNT_W-1:0] out_vao_request_count,
  input wire logic [COUNT_W-1:0] out_vao_bind_count,
  input wire logic [COUNT_W-1:0] out_tex_request_count,
  input wire logic [COUNT_W-1:0] out_tex_bind_count
);

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_action) ^ (^in_unit) ^ (^in_object_name);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_fwd_name)
        && $stable(out_tex_bind_count) && $stable(out_emit_tex_bind)
        && $stable(out_vao_request_count) && $stable(out_vao_bind_count)
        && $stable(out_tex_request_count))
    else $error("stalled result changed");

  a_vao_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_emit_vao_bind |-> !out_emit_unit_select && !out_emit_tex_bind
        && !out_verify_sample && !out_bound_hit)
    else $error("vertex array bind mixed with texture flags");

  a_sample_skipped: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_verify_sample |-> !out_emit_tex_bind && !out_bound_hit)
    else $error("sample flagged on a forwarded texture bind");

  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_bound_hit |-> !out_emit_unit_select && !out_emit_tex_bind
        && out_fwd_unit == '0 && out_fwd_name == '0)
    else $error("query answer carries forwarded data");

endmodule

bind bind_state_redundancy_filter bsrf_checker u_bsrf_checker (.*);

`default_nettype wire

@@ bench/bind_state_redundancy_filter_tb.sv @@
// Testbench for the bind state redundancy filter: directed and random command streams.
// Depends on bsrf_pkg and bind_state_redundancy_filter; predicts each result
// in its own model of the binding cache and checks every transfer field by field.
`default_nettype none

module bind_state_redundancy_filter_tb;
  import bsrf_pkg::*;

  localparam int TB_CACHED_UNITS = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 550;
  localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action = '0;
  logic [UNIT_W-1:0]  in_unit = '0;
  logic [NAME_W-1:0]  in_object_name = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_emit_vao_bind;
  logic               out_emit_unit_select;
  logic               out_emit_tex_bind;
  logic [UNIT_W-1:0]  out_fwd_unit;
  logic [NAME_W-1:0]  out_fwd_name;
  logic               out_verify_sample;
  logic               out_bound_hit;
  logic [COUNT_W-1:0] out_vao_request_count;
  logic [COUNT_W-1:0] out_vao_bind_count;
  logic [COUNT_W-1:0] out_tex_request_count;
  logic [COUNT_W-1:0] out_tex_bind_count;

  bind_state_redundancy_filter #(
    .CACHED_UNITS(TB_CACHED_UNITS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_unit              (in_unit),
    .in_object_name       (in_object_name),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_emit_vao_bind    (out_emit_vao_bind),
    .out_emit_unit_select (out_emit_unit_select),
    .out_emit_tex_bind    (out_emit_tex_bind),
    .out_fwd_unit         (out_fwd_unit),
    .out_fwd_name         (out_fwd_name),
    .out_verify_sample    (out_verify_sample),
    .out_bound_hit        (out_bound_hit),
    .out_vao_request_count(out_vao_request_count),
    .out_vao_bind_count   (out_vao_bind_count),
    .out_tex_request_count(out_tex_request_count),
    .out_tex_bind_count   (out_tex_bind_count)
  );

  always #5 clk = ~clk;

  logic [NAME_W-1:0]  shadow_vao;
  logic [NAME_W-1:0]  shadow_tex [TB_CACHED_UNITS];
  logic [UNIT_W-1:0]  shadow_unit;
  logic               shadow_unit_known;
  logic [SKIP_W-1:0]  shadow_skip [TB_CACHED_UNITS];
  logic [COUNT_W-1:0] shadow_vao_requests;
  logic [COUNT_W-1:0] shadow_vao_binds;
  logic [COUNT_W-1:0] shadow_tex_requests;
  logic [COUNT_W-1:0] shadow_tex_binds;

  result_t            expected_results [$];
  result_t            oldest_result;
  logic [NAME_W-1:0]  name_pool [4];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int                 stall_mode = 0;

  task automatic clear_shadow_cache();
    shadow_vao = UNKNOWN_NAME;
    for (int i = 0; i < TB_CACHED_UNITS; i++) begin
      shadow_tex[i] = UNKNOWN_NAME;
      shadow_skip[i] = '0;
    end
    shadow_unit = '0;
    shadow_unit_known = 1'b0;
    shadow_vao_requests = '0;
    shadow_vao_binds = '0;
    shadow_tex_requests = '0;
    shadow_tex_binds = '0;
  endtask

  function automatic result_t filter_bind(input cmd_t c);
    result_t r;
    logic    in_cache;
    r = '0;
    in_cache = (int'(c.unit) < TB_CACHED_UNITS);
    case (c.action)
      ACT_VAO_BIND: begin
        shadow_vao_requests++;
        if (c.object_name != shadow_vao) begin
          shadow_vao = c.object_name;
          shadow_vao_binds++;
          r.emit_vao_bind = 1'b1;
          r.fwd_name = c.object_name;
        end
      end
      ACT_TEX_BIND: begin
        shadow_tex_requests++;
        if (!shadow_unit_known || shadow_unit != c.unit) begin
          shadow_unit = c.unit;
          shadow_unit_known = 1'b1;
          r.emit_unit_select = 1'b1;
          r.fwd_unit = c.unit;
        end
        if (in_cache && shadow_tex[c.unit] == c.object_name) begin
          if (shadow_skip[c.unit] == '0) r.verify_sample = 1'b1;
          shadow_skip[c.unit] = shadow_skip[c.unit] + SKIP_W'(1);
        end else begin
          if (in_cache) shadow_tex[c.unit] = c.object_name;
          shadow_tex_binds++;
          r.emit_tex_bind = 1'b1;
          r.fwd_unit = c.unit;
          r.fwd_name = c.object_name;
        end
      end
      ACT_VAO_DELETE: begin
        if (shadow_vao == c.object_name) shadow_vao = UNKNOWN_NAME;
      end
      ACT_TEX_DELETE: begin
        for (int i = 0; i < TB_CACHED_UNITS; i++)
          if (shadow_tex[i] == c.object_name) shadow_tex[i] = UNKNOWN_NAME;
      end
      ACT_BOUND_QUERY: begin
        r.bound_hit = in_cache && (shadow_tex[c.unit] == c.object_name);
      end
      ACT_INVALIDATE: begin
        shadow_vao = UNKNOWN_NAME;
        for (int i = 0; i < TB_CACHED_UNITS; i++) shadow_tex[i] = UNKNOWN_NAME;
        shadow_unit_known = 1'b0;
      end
      default: begin
      end
    endcase
    r.vao_request_count = shadow_vao_requests;
    r.vao_bind_count = shadow_vao_binds;
    r.tex_request_count = shadow_tex_requests;
    r.tex_bind_count = shadow_tex_binds;
    return r;
  endfunction

  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [UNIT_W-1:0] u,
                          input logic [NAME_W-1:0] nm);
    cmd_t c;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_action <= ACT_W'($urandom);
        in_unit <= UNIT_W'($urandom);
        in_object_name <= $urandom;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_unit <= u;
    in_object_name <= nm;
    do @(posedge clk); while (in_stall !== 1'b0);
    c.action = act;
    c.unit = u;
    c.object_name = nm;
    expected_results.push_back(filter_bind(c));
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic check_field(input string field, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("emit_vao_bind", 64'(oldest_result.emit_vao_bind),
                    64'(out_emit_vao_bind));
        check_field("emit_unit_select", 64'(oldest_result.emit_unit_select),
                    64'(out_emit_unit_select));
        check_field("emit_tex_bind", 64'(oldest_result.emit_tex_bind),
                    64'(out_emit_tex_bind));
        check_field("fwd_unit", 64'(oldest_result.fwd_unit), 64'(out_fwd_unit));
        check_field("fwd_name", 64'(oldest_result.fwd_name), 64'(out_fwd_name));
        check_field("verify_sample", 64'(oldest_result.verify_sample),
                    64'(out_verify_sample));
        check_field("bound_hit", 64'(oldest_result.bound_hit), 64'(out_bound_hit));
        check_field("vao_request_count", oldest_result.vao_request_count,
                    out_vao_request_count);
        check_field("vao_bind_count", oldest_result.vao_bind_count, out_vao_bind_count);
        check_field("tex_request_count", oldest_result.tex_request_count,
                    out_tex_request_count);
        check_field("tex_bind_count", oldest_result.tex_bind_count, out_tex_bind_count);
      end
    end
  end

  always @(negedge clk) begin
    if (cycle_count % 64 == 0) stall_mode = (cycle_count == 0) ? 0 : $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= cycle_count[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_vao_filtering();
    send_cmd(ACT_VAO_BIND, 8'h00, UNKNOWN_NAME);
    send_cmd(ACT_VAO_BIND, 8'h00, 32'h0000_0000);
    send_cmd(ACT_VAO_BIND, 8'hff, 32'h0000_0000);
    send_cmd(ACT_VAO_DELETE, 8'h00, 32'h0000_0005);
    send_cmd(ACT_VAO_DELETE, 8'h00, 32'h0000_0000);
    send_cmd(ACT_VAO_BIND, 8'h00, 32'h0000_0000);
  endtask

  task automatic test_texture_filtering();
    send_cmd(ACT_TEX_BIND, 8'd0, 32'h1234_5678);
    send_cmd(ACT_TEX_BIND, 8'd0, 32'h1234_5678);
    send_cmd(ACT_TEX_BIND, 8'd7, UNKNOWN_NAME);
    send_cmd(ACT_TEX_BIND, 8'd255, 32'ha5a5_a5a5);
    send_cmd(ACT_TEX_BIND, 8'd8, 32'ha5a5_a5a5);
    send_cmd(ACT_TEX_BIND, 8'd8, 32'ha5a5_a5a5);
    send_cmd(ACT_TEX_BIND, 8'd3, 32'h1234_5678);
    send_cmd(ACT_BOUND_QUERY, 8'd0, 32'h1234_5678);
    send_cmd(ACT_BOUND_QUERY, 8'd255, 32'ha5a5_a5a5);
    send_cmd(ACT_TEX_DELETE, 8'd0, 32'h1234_5678);
    send_cmd(ACT_BOUND_QUERY, 8'd0, 32'h1234_5678);
  endtask

  task automatic test_invalidate_and_reserved();
    send_cmd(ACT_INVALIDATE, 8'd0, 32'h0000_0000);
    send_cmd(ACT_RESERVED_A, 8'h55, 32'h0000_0000);
    send_cmd(ACT_RESERVED_B, 8'haa, UNKNOWN_NAME);
    send_cmd(ACT_VAO_BIND, 8'd0, 32'h0000_0000);
    send_cmd(ACT_TEX_BIND, 8'd7, 32'h0000_0000);
    send_cmd(ACT_BOUND_QUERY, 8'd7, 32'h0000_0000);
  endtask

  function automatic logic [NAME_W-1:0] pick_name();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return name_pool[$urandom_range(0, 3)];
    if (roll < 75) return UNKNOWN_NAME;
    return $urandom;
  endfunction

  function automatic logic [UNIT_W-1:0] pick_unit();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return UNIT_W'($urandom_range(0, 2));
    if (roll < 75) return UNIT_W'($urandom_range(0, TB_CACHED_UNITS - 1));
    if (roll < 85) return UNIT_W'($urandom_range(TB_CACHED_UNITS, 15));
    return UNIT_W'($urandom_range(0, 255));
  endfunction

  task automatic test_random_stream(input int count);
    int roll;
    for (int i = 0; i < 4; i++) name_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 45) send_cmd(ACT_TEX_BIND, pick_unit(), pick_name());
      else if (roll < 63) send_cmd(ACT_VAO_BIND, UNIT_W'($urandom), pick_name());
      else if (roll < 75) send_cmd(ACT_BOUND_QUERY, pick_unit(), pick_name());
      else if (roll < 83) send_cmd(ACT_VAO_DELETE, UNIT_W'($urandom), pick_name());
      else if (roll < 91) send_cmd(ACT_TEX_DELETE, UNIT_W'($urandom), pick_name());
      else if (roll < 95) send_cmd(ACT_INVALIDATE, UNIT_W'($urandom), $urandom);
      else send_cmd(ACT_W'($urandom_range(ACT_RESERVED_A, ACT_RESERVED_B)),
                    UNIT_W'($urandom), $urandom);
    end
  endtask

  initial begin
    clear_shadow_cache();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_vao_filtering();
    test_texture_filtering();
    test_invalidate_and_reserved();
    wait_drained();
    test_random_stream(RANDOM_ITEMS);
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bsrf_pkg.sv
rtl/bsrf_in_stage.sv
rtl/bsrf_state.sv
rtl/bsrf_out_stage.sv
rtl/bind_state_redundancy_filter.sv
rtl/bsrf_checker.sv
bench/bind_state_redundancy_filter_tb.sv
